[hdl/sliding_window_median_core_defines.svh]
// Assertion helpers for the median filter RTL
`ifndef SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SWM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("median filter check failed");

// Next-cycle implication, checked out of reset
`define SWM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

[hdl/swm_pkg.sv]
package swm_pkg;

    // window geometry
    localparam int WINDOW_MAX = 64;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 7;
    localparam int WSIZE_RST  = 3;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    // what each cell shows its neighbours
    typedef struct packed {
        t_sample value;
        logic    valid;   // holds a window entry (already masked by a stream restart)
        logic    gt;      // value above the incoming sample
        logic    del;     // at or above the departing sample: removal point is here or below
    } t_cell_link;

    // broadcast to every cell
    typedef struct packed {
        t_sample sample;  // incoming sample
        t_sample old;     // departing (oldest) sample
        logic    en;      // transaction accepted this cycle
        logic    clear;   // transaction starts a new stream
        logic    full;    // window full: drop oldest while inserting
        logic    flush;   // window size rewritten: empty the chain
    } t_cell_bcast;

endpackage

[hdl/sliding_window_median_core.sv]
// Running median filter over a sliding window of signed 32-bit samples.
// Input stream (s_axis): one sample per transaction in tdata; tuser set marks
// the first sample of a new stream and empties the window before it is taken.
// Output stream (m_axis): the lower median of the full window, one result per
// sample once window_size samples of the current stream have arrived; the
// first window_size-1 samples of a stream give no result.
// Configuration: i_cfg_we writes window_size (0 acts as 1, above 64 as 64)
// and empties the window; write it only while the block is idle.
// Throughput: one sample per cycle unless the output side stalls. A row of 64
// sorting cells removes the oldest sample and inserts the new one together, and
// the oldest sample is prefetched from the arrival memory by its registered read.
// A result passes through the pending stage into the output register for m_axis.
// Reset (synchronous, active low) empties the window, sets window_size to 3
// and drops any pending result; the memory needs no clearing pass.
// Receiver stall: one result waits in the output register and one more in a
// pending stage; s_axis_tready falls only while both are occupied.
`include "sliding_window_median_core_defines.svh"

module sliding_window_median_core
    import swm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,   // window_size
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // [31:0] sample
    input  logic              s_axis_tuser,  // [0] stream_start
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata   // [31:0] median
);

    t_cnt    r_wsize;
    t_idx    r_mid;
    t_cnt    r_fill;
    t_idx    r_ptr;
    logic    r_pend;
    logic    r_oval;
    t_sample r_odata;

    t_cnt    n_wsize;
    t_cnt    n_fill;
    t_idx    n_ptr;
    logic    n_pend;
    logic    n_oval;

    logic        w_acc;
    t_cnt        w_fill_eff;
    logic        w_full;
    logic        w_emit;
    t_cnt        w_ptr_inc;
    logic        w_load;
    t_idx        w_wr_addr;
    t_sample     w_old;
    t_cell_bcast w_bc;
    t_cell_link  w_link [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] w_valid_vec;

    assign w_acc      = s_axis_tvalid & s_axis_tready;
    assign w_fill_eff = s_axis_tuser ? '0 : r_fill;
    assign w_full     = (w_fill_eff == r_wsize);
    assign w_emit     = w_full | (CNT_W'(w_fill_eff + 1'b1) == r_wsize);
    assign w_ptr_inc  = CNT_W'({1'b0, r_ptr} + 1'b1);
    assign w_wr_addr  = w_full ? r_ptr : w_fill_eff[IDX_W-1:0];

    // clamped window size from the configuration value
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_wsize = CNT_W'(1);
        end else if (int'(i_cfg_wdata) > WINDOW_MAX) begin
            n_wsize = CNT_W'(WINDOW_MAX);
        end else begin
            n_wsize = CNT_W'(i_cfg_wdata);
        end
    end

    // fill count and oldest-slot pointer
    always_comb begin
        n_fill = r_fill;
        n_ptr  = r_ptr;
        priority if (i_cfg_we) begin
            n_fill = '0;
            n_ptr  = '0;
        end else if (w_acc) begin
            if (w_full) begin
                n_ptr = (w_ptr_inc == r_wsize) ? '0 : w_ptr_inc[IDX_W-1:0];
            end else begin
                n_fill = CNT_W'(w_fill_eff + 1'b1);
                n_ptr  = '0;
            end
        end
    end

    // output register plus one pending result
    always_comb begin
        w_load        = r_pend & (~r_oval | m_axis_tready);
        s_axis_tready = ~r_pend | w_load;
        n_oval        = w_load | (r_oval & ~m_axis_tready);
        n_pend        = (w_acc & w_emit) | (r_pend & ~w_load);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= CNT_W'(WSIZE_RST);
            r_mid   <= IDX_W'((WSIZE_RST - 1) / 2);
            r_fill  <= '0;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wsize <= n_wsize;
                r_mid   <= IDX_W'((n_wsize - 1'b1) >> 1);
            end
            r_fill <= n_fill;
            r_ptr  <= n_ptr;
            r_pend <= n_pend;
            r_oval <= n_oval;
        end
    end

    // median tap of the sorted chain, taken as the pending result moves to the output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= w_link[r_mid].value;
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    // arrival-order store; read address tracks the next oldest slot
    swm_ring u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (t_sample'(s_axis_tdata)),
        .i_rd_addr (n_ptr),
        .o_rd_data (w_old)
    );

    assign w_bc = '{sample: t_sample'(s_axis_tdata),
                    old:    w_old,
                    en:     w_acc,
                    clear:  w_acc & s_axis_tuser,
                    full:   w_full,
                    flush:  i_cfg_we};

    // sorted chain of cells, ascending from cell 0
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        t_cell_link w_lo;
        t_cell_link w_hi;
        if (gi == 0) begin : g_lo_end
            assign w_lo = '{value: '0, valid: 1'b1, gt: 1'b0, del: 1'b0};
        end else begin : g_lo_mid
            assign w_lo = w_link[gi-1];
        end
        if (gi == WINDOW_MAX - 1) begin : g_hi_end
            assign w_hi = '{value: '0, valid: 1'b0, gt: 1'b0, del: 1'b0};
        end else begin : g_hi_mid
            assign w_hi = w_link[gi+1];
        end
        swm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lo    (w_lo),
            .i_hi    (w_hi),
            .i_bc    (w_bc),
            .o_link  (w_link[gi])
        );
        assign w_valid_vec[gi] = w_link[gi].valid;
    end

    // checks
    `SWM_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= r_wsize)
    `SWM_ASSERT_IMP(a_valid_count, !w_bc.clear, $countones(w_valid_vec) == int'(r_fill))
    `SWM_ASSERT_IMP(a_ptr_idle, r_fill != r_wsize, r_ptr == '0)
    `SWM_ASSERT_NXT(a_pend_hold, r_pend && !w_load, r_pend && r_oval)

endmodule

[hdl/swm_cell.sv]
module swm_cell
    import swm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_link  i_lo,     // neighbour one place lower in sorted order
    input  t_cell_link  i_hi,     // neighbour one place higher
    input  t_cell_bcast i_bc,
    output t_cell_link  o_link
);

    t_sample r_value;
    logic    r_valid;
    t_sample n_value;
    logic    n_valid;

    logic    w_valid;
    logic    w_gt;
    logic    w_del;
    t_sample w_u_self;
    logic    w_uv_self;
    logic    w_gu_self;
    t_sample w_u_lo;
    logic    w_gu_lo;

    // local compares against the broadcast values
    assign w_valid = r_valid & ~i_bc.clear;
    assign w_gt    = w_valid & ($signed(r_value) > $signed(i_bc.sample));
    assign w_del   = i_bc.full & w_valid & ($signed(r_value) >= $signed(i_bc.old));

    assign o_link = '{value: r_value, valid: w_valid, gt: w_gt, del: w_del};

    // contents after removal of the oldest sample, here and one place down
    always_comb begin
        w_u_self  = w_del ? i_hi.value : r_value;
        w_uv_self = w_del ? i_hi.valid : w_valid;
        w_gu_self = w_del ? i_hi.gt    : w_gt;
        w_u_lo    = i_lo.del ? r_value : i_lo.value;
        w_gu_lo   = i_lo.del ? w_gt    : i_lo.gt;
    end

    // insertion of the new sample into the reduced list
    always_comb begin
        if (w_gu_lo) begin
            n_value = w_u_lo;
        end else if (w_gu_self || !w_uv_self) begin
            n_value = i_bc.sample;
        end else begin
            n_value = w_u_self;
        end
        n_valid = i_bc.full ? w_valid : (w_valid | i_lo.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_bc.flush) begin
            r_valid <= 1'b0;
        end else if (i_bc.en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bc.en) begin
            r_value <= n_value;
        end
    end

endmodule

[hdl/swm_ring.sv]
module swm_ring
    import swm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_wr_en,
    input  t_idx    i_wr_addr,
    input  t_sample i_wr_data,
    input  t_idx    i_rd_addr,
    output t_sample o_rd_data
);

    t_sample r_mem [WINDOW_MAX];
    t_sample r_rd;

    // arrival-order store, one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, new data forwarded on an address collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd <= i_wr_data;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule
